// File: design/v86m_pkg.sv
// ----------------------------------------------------------------------------
// v86m_pkg
// Shared types and codes of the virtual-8086 sensitive-op monitor.
// ----------------------------------------------------------------------------
package v86m_pkg;

	localparam logic [2:0] RK_STACK_WR = 3'd0;
	localparam logic [2:0] RK_PORT_RD  = 3'd1;
	localparam logic [2:0] RK_PORT_WR  = 3'd2;
	localparam logic [2:0] RK_PREFIX   = 3'd3;
	localparam logic [2:0] RK_HANDLED  = 3'd4;
	localparam logic [2:0] RK_TO_HOST  = 3'd5;
	localparam logic [2:0] RK_UNHANDLED = 3'd6;
	localparam logic [2:0] RK_REG_WR   = 3'd7;

	localparam logic [7:0] OP_OPSIZE = 8'h66;
	localparam logic [7:0] OP_ADSIZE = 8'h67;
	localparam logic [7:0] OP_PUSHF  = 8'h9C;
	localparam logic [7:0] OP_POPF   = 8'h9D;
	localparam logic [7:0] OP_INT    = 8'hCD;
	localparam logic [7:0] OP_IRET   = 8'hCF;
	localparam logic [7:0] OP_INB    = 8'hEC;
	localparam logic [7:0] OP_INW    = 8'hED;
	localparam logic [7:0] OP_OUTB   = 8'hEE;
	localparam logic [7:0] OP_OUTW   = 8'hEF;
	localparam logic [7:0] OP_CLI    = 8'hFA;
	localparam logic [7:0] OP_STI    = 8'hFB;
	localparam logic [7:0] VEC_HOST  = 8'h30;

	localparam logic [2:0] REG_IP = 3'd0;
	localparam logic [2:0] REG_CS = 3'd1;
	localparam logic [2:0] REG_SP = 3'd2;
	localparam logic [2:0] REG_SS = 3'd3;
	localparam logic [2:0] REG_FLAGS = 3'd4;
	localparam logic [2:0] REG_EAX = 3'd5;
	localparam logic [2:0] REG_DX = 3'd6;
	localparam logic [2:0] REG_VIF = 3'd7;

	localparam logic [31:0] FLAGS_FIXED = 32'h0002_0200;
	localparam logic [15:0] POPF_MASK   = 16'h0DFF;
	localparam logic [15:0] VIF_BIT     = 16'h0200;

	localparam int unsigned MAX_RES = 4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [20:0] addr;
		logic [31:0] data;
		logic [1:0]  width;
	} res_t;

	// one executed item after decode: all results plus final guest state
	typedef struct packed {
		logic [2:0]  count;
		res_t [MAX_RES-1:0] res;
		logic [15:0] ip;
		logic [15:0] cs;
		logic [15:0] sp;
		logic [31:0] flags;
		logic [31:0] eax;
		logic        vif;
	} job_t;

endpackage

// File: design/v86m_front.sv
// ----------------------------------------------------------------------------
// v86m_front
// Accepts items, keeps the guest registers and decodes each item into a job.
// ----------------------------------------------------------------------------
module v86m_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 item_kind,
	input  logic [2:0]           reg_select,
	input  logic [31:0]          reg_value,
	input  logic [7:0]           code_byte,
	input  logic [7:0]           next_code_byte,
	input  logic [15:0]          stack_word0,
	input  logic [15:0]          stack_word1,
	input  logic [15:0]          stack_word2,
	input  logic [15:0]          vector_offset,
	input  logic [15:0]          vector_segment,
	input  logic [31:0]          port_read_data,
	input  logic                 q_full,
	output logic                 job_valid,
	output v86m_pkg::job_t       job
);

	logic [15:0] ip_q, cs_q, sp_q, ss_q, dx_q;
	logic [31:0] flags_q, eax_q;
	logic        vif_q, o32_q, a32_q;

	logic [15:0] ip_d, cs_d, sp_d;
	logic [31:0] flags_d, eax_d;
	logic        vif_d, o32_d, a32_d;
	logic [15:0] ss_d, dx_d;
	logic [15:0] fw, sp6, sp4, sp2;
	logic        acc;

	assign in_ready  = !q_full;
	assign acc       = in_valid && in_ready;
	assign job_valid = acc;

	assign fw  = vif_q ? (flags_q[15:0] | v86m_pkg::VIF_BIT)
	                   : (flags_q[15:0] & ~v86m_pkg::VIF_BIT);
	assign sp6 = sp_q - 16'd6;
	assign sp4 = sp_q - 16'd4;
	assign sp2 = sp_q - 16'd2;

	function automatic v86m_pkg::res_t mk(input logic [2:0] k, input logic [20:0] a,
		input logic [31:0] d, input logic [1:0] w);
		v86m_pkg::res_t r;
		r.kind = k; r.addr = a; r.data = d; r.width = w;
		return r;
	endfunction

	function automatic logic [20:0] saddr(input logic [15:0] ss, input logic [15:0] off);
		return {1'b0, ss, 4'd0} + {5'd0, off};
	endfunction

	always_comb begin
		ip_d = ip_q; cs_d = cs_q; sp_d = sp_q; ss_d = ss_q; dx_d = dx_q;
		flags_d = flags_q; eax_d = eax_q; vif_d = vif_q;
		o32_d = 1'b0; a32_d = 1'b0;
		job = '0;
		job.count = 3'd1;
		job.res[0] = mk(v86m_pkg::RK_HANDLED, '0, '0, '0);
		if (item_kind) begin
			o32_d = o32_q; a32_d = a32_q;
			job.res[0] = mk(v86m_pkg::RK_REG_WR, '0, '0, '0);
			unique case (reg_select)
				v86m_pkg::REG_IP:    ip_d = reg_value[15:0];
				v86m_pkg::REG_CS:    cs_d = reg_value[15:0];
				v86m_pkg::REG_SP:    sp_d = reg_value[15:0];
				v86m_pkg::REG_SS:    ss_d = reg_value[15:0];
				v86m_pkg::REG_FLAGS: flags_d = reg_value;
				v86m_pkg::REG_EAX:   eax_d = reg_value;
				v86m_pkg::REG_DX:    dx_d = reg_value[15:0];
				default:             vif_d = reg_value[0];
			endcase
		end else begin
			unique case (code_byte)
				v86m_pkg::OP_OPSIZE, v86m_pkg::OP_ADSIZE: begin
					o32_d = o32_q | (code_byte == v86m_pkg::OP_OPSIZE);
					a32_d = a32_q | (code_byte == v86m_pkg::OP_ADSIZE);
					ip_d = ip_q + 16'd1;
					job.res[0] = mk(v86m_pkg::RK_PREFIX, '0, '0, '0);
				end
				v86m_pkg::OP_PUSHF: begin
					ip_d = ip_q + 16'd1;
					if (o32_q) begin
						sp_d = sp4;
						job.count = 3'd3;
						job.res[0] = mk(v86m_pkg::RK_STACK_WR, saddr(ss_q, sp4),
							{16'd0, fw}, 2'd1);
						job.res[1] = mk(v86m_pkg::RK_STACK_WR, saddr(ss_q, sp2),
							{16'd0, flags_q[31:16]}, 2'd1);
						job.res[2] = mk(v86m_pkg::RK_HANDLED, '0, '0, '0);
					end else begin
						sp_d = sp2;
						job.count = 3'd2;
						job.res[0] = mk(v86m_pkg::RK_STACK_WR, saddr(ss_q, sp2),
							{16'd0, fw}, 2'd1);
						job.res[1] = mk(v86m_pkg::RK_HANDLED, '0, '0, '0);
					end
				end
				v86m_pkg::OP_POPF: begin
					flags_d = v86m_pkg::FLAGS_FIXED | {16'd0, stack_word0 & v86m_pkg::POPF_MASK};
					vif_d = stack_word0[9];
					sp_d = sp_q + (o32_q ? 16'd4 : 16'd2);
					ip_d = ip_q + 16'd1;
				end
				v86m_pkg::OP_INT: begin
					if (next_code_byte == v86m_pkg::VEC_HOST) begin
						job.res[0] = mk(v86m_pkg::RK_TO_HOST, '0, '0, '0);
					end else begin
						sp_d = sp6;
						ip_d = vector_offset;
						cs_d = vector_segment;
						job.count = 3'd4;
						job.res[0] = mk(v86m_pkg::RK_STACK_WR, saddr(ss_q, sp6),
							{16'd0, ip_q + 16'd2}, 2'd1);
						job.res[1] = mk(v86m_pkg::RK_STACK_WR, saddr(ss_q, sp4),
							{16'd0, cs_q}, 2'd1);
						job.res[2] = mk(v86m_pkg::RK_STACK_WR, saddr(ss_q, sp2),
							{16'd0, fw}, 2'd1);
						job.res[3] = mk(v86m_pkg::RK_HANDLED, '0, '0, '0);
					end
				end
				v86m_pkg::OP_IRET: begin
					ip_d = stack_word0;
					cs_d = stack_word1;
					flags_d = {16'd0, stack_word2} | v86m_pkg::FLAGS_FIXED;
					vif_d = stack_word2[9];
					sp_d = sp_q + 16'd6;
				end
				v86m_pkg::OP_INB, v86m_pkg::OP_INW, v86m_pkg::OP_OUTB,
				v86m_pkg::OP_OUTW: begin
					ip_d = ip_q + 16'd1;
					job.count = 3'd2;
					job.res[1] = mk(v86m_pkg::RK_HANDLED, '0, '0, '0);
					unique case (code_byte)
						v86m_pkg::OP_INB: begin
							eax_d = {eax_q[31:8], port_read_data[7:0]};
							job.res[0] = mk(v86m_pkg::RK_PORT_RD, {5'd0, dx_q},
								{24'd0, port_read_data[7:0]}, 2'd0);
						end
						v86m_pkg::OP_INW: begin
							if (o32_q) begin
								eax_d = port_read_data;
								job.res[0] = mk(v86m_pkg::RK_PORT_RD, {5'd0, dx_q},
									port_read_data, 2'd2);
							end else begin
								eax_d = {eax_q[31:16], port_read_data[15:0]};
								job.res[0] = mk(v86m_pkg::RK_PORT_RD, {5'd0, dx_q},
									{16'd0, port_read_data[15:0]}, 2'd1);
							end
						end
						v86m_pkg::OP_OUTB:
							job.res[0] = mk(v86m_pkg::RK_PORT_WR, {5'd0, dx_q},
								{24'd0, eax_q[7:0]}, 2'd0);
						default: begin
							if (o32_q)
								job.res[0] = mk(v86m_pkg::RK_PORT_WR, {5'd0, dx_q},
									eax_q, 2'd2);
							else
								job.res[0] = mk(v86m_pkg::RK_PORT_WR, {5'd0, dx_q},
									{16'd0, eax_q[15:0]}, 2'd1);
						end
					endcase
				end
				v86m_pkg::OP_CLI, v86m_pkg::OP_STI: begin
					vif_d = (code_byte == v86m_pkg::OP_STI);
					ip_d = ip_q + 16'd1;
				end
				default: job.res[0] = mk(v86m_pkg::RK_UNHANDLED, '0, '0, '0);
			endcase
		end
		job.ip = ip_d; job.cs = cs_d; job.sp = sp_d;
		job.flags = flags_d; job.eax = eax_d; job.vif = vif_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q <= '0; cs_q <= '0; sp_q <= '0; ss_q <= '0; dx_q <= '0;
			flags_q <= v86m_pkg::FLAGS_FIXED; eax_q <= '0;
			vif_q <= 1'b0; o32_q <= 1'b0; a32_q <= 1'b0;
		end else if (acc) begin
			ip_q <= ip_d; cs_q <= cs_d; sp_q <= sp_d; ss_q <= ss_d; dx_q <= dx_d;
			flags_q <= flags_d; eax_q <= eax_d;
			vif_q <= vif_d; o32_q <= o32_d; a32_q <= a32_d;
		end
	end

endmodule

// File: design/v86m_queue.sv
// ----------------------------------------------------------------------------
// v86m_queue
// Two-entry job queue between decode and result issue.
// ----------------------------------------------------------------------------
module v86m_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  v86m_pkg::job_t wr_job,
	output logic           full,
	output logic           rd_valid,
	input  logic           rd_en,
	output v86m_pkg::job_t rd_job
);

	v86m_pkg::job_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_job   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

endmodule

// File: design/v86m_back.sv
// ----------------------------------------------------------------------------
// v86m_back
// Issues the results of each queued job one per cycle into an output register, while out_ready does not stall it.
// ----------------------------------------------------------------------------
module v86m_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  v86m_pkg::job_t job,
	output logic           job_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     result_kind,
	output logic [20:0]    target_address,
	output logic [31:0]    write_data,
	output logic [1:0]     access_width,
	output logic           last_result,
	output logic [15:0]    guest_ip_out,
	output logic [15:0]    guest_cs_out,
	output logic [15:0]    guest_sp_out,
	output logic [31:0]    guest_flags_out,
	output logic [31:0]    guest_eax_out,
	output logic           virtual_if_out
);

	logic [1:0]      idx_q;
	logic            ov_q;
	v86m_pkg::res_t  res_q;
	logic            last_q;
	logic            load, is_last;

	assign load    = job_valid && (!ov_q || out_ready);
	assign is_last = ({1'b0, idx_q} + 3'd1 == job.count);
	assign job_pop = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0; idx_q <= '0;
		end else begin
			if (load) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			if (load) idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= job.res[idx_q];
			last_q <= is_last;
			guest_ip_out <= job.ip;
			guest_cs_out <= job.cs;
			guest_sp_out <= job.sp;
			guest_flags_out <= job.flags;
			guest_eax_out <= job.eax;
			virtual_if_out <= job.vif;
		end
	end

	assign out_valid      = ov_q;
	assign result_kind    = res_q.kind;
	assign target_address = res_q.addr;
	assign write_data     = res_q.data;
	assign access_width   = res_q.width;
	assign last_result    = last_q;

endmodule

// File: design/virtual_8086_sensitive_op_monitor.sv
// ----------------------------------------------------------------------------
// virtual_8086_sensitive_op_monitor
// Emulates trapped sensitive instructions of a real-address-mode guest.
// ----------------------------------------------------------------------------
// An item is decoded and the guest registers updated in the cycle it is
// accepted; its results (one to four, four at most for an INT) leave one per
// cycle from an output register while out_ready does not stall them. A
// two-entry job queue lets the front take items while the back still issues
// results; the result issue port sets the rate.
module virtual_8086_sensitive_op_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        item_kind,
	input  logic [2:0]  reg_select,
	input  logic [31:0] reg_value,
	input  logic [7:0]  code_byte,
	input  logic [7:0]  next_code_byte,
	input  logic [15:0] stack_word0,
	input  logic [15:0] stack_word1,
	input  logic [15:0] stack_word2,
	input  logic [15:0] vector_offset,
	input  logic [15:0] vector_segment,
	input  logic [31:0] port_read_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  result_kind,
	output logic [20:0] target_address,
	output logic [31:0] write_data,
	output logic [1:0]  access_width,
	output logic        last_result,
	output logic [15:0] guest_ip_out,
	output logic [15:0] guest_cs_out,
	output logic [15:0] guest_sp_out,
	output logic [31:0] guest_flags_out,
	output logic [31:0] guest_eax_out,
	output logic        virtual_if_out
);

	logic           q_full, f_valid, q_valid, q_pop;
	v86m_pkg::job_t f_job, q_job;

	v86m_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .item_kind, .reg_select, .reg_value,
		.code_byte, .next_code_byte, .stack_word0, .stack_word1, .stack_word2,
		.vector_offset, .vector_segment, .port_read_data,
		.q_full(q_full), .job_valid(f_valid), .job(f_job)
	);

	v86m_queue u_queue (
		.clk, .arst_n, .wr_en(f_valid), .wr_job(f_job), .full(q_full),
		.rd_valid(q_valid), .rd_en(q_pop), .rd_job(q_job)
	);

	v86m_back u_back (
		.clk, .arst_n, .job_valid(q_valid), .job(q_job), .job_pop(q_pop),
		.out_valid, .out_ready, .result_kind, .target_address, .write_data,
		.access_width, .last_result, .guest_ip_out, .guest_cs_out, .guest_sp_out,
		.guest_flags_out, .guest_eax_out, .virtual_if_out
	);

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("job popped from empty queue");
	a_stack_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == v86m_pkg::RK_STACK_WR) |-> access_width == 2'd1)
		else $error("stack write not word wide");
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (result_kind == v86m_pkg::RK_HANDLED
		|| result_kind == v86m_pkg::RK_REG_WR || result_kind == v86m_pkg::RK_PREFIX))
		|-> last_result) else $error("status result not last");
`endif

endmodule
